[rtl/wosc_pkg.sv]
// Package for the wavetable oscillator: table geometry, datapath widths,
// controller state codes, configuration register indexes and shared types.
// No dependencies; wosc_dp, the top level and the testbench import it.
package wosc_pkg;

  localparam int TABLE_BITS = 10;
  localparam int NUM_WAVES  = 4;
  localparam int FRAC_BITS  = 22;

  localparam int TSIZE      = 1 << TABLE_BITS;
  localparam int PHASE_BITS = TABLE_BITS + FRAC_BITS;
  localparam int STORE_DEPTH = NUM_WAVES * TSIZE;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int SAMPLE_W    = 16;

  // Interpolation and scaling widths.
  localparam int IW  = FRAC_BITS + 18;
  localparam int LW  = IW / 2;
  localparam int HW  = IW - LW;
  localparam int FW  = IW + 17;
  localparam int SH  = FRAC_BITS + 14;

  // Pitch-scaled step widths.
  localparam int PPW = 49;
  localparam int SEW = (PHASE_BITS > 35) ? PHASE_BITS : 35;

  localparam int CFG_W = 32;

  localparam logic [1:0] CFG_WAVE_SELECT  = 2'd0;
  localparam logic [1:0] CFG_PHASE_STEP   = 2'd1;
  localparam logic [1:0] CFG_AMPLITUDE    = 2'd2;
  localparam logic [1:0] CFG_PITCH_ENABLE = 2'd3;

  localparam logic [1:0]  RST_WAVE_SELECT  = 2'd0;
  localparam logic [31:0] RST_PHASE_STEP   = 32'd41943040;
  localparam logic [15:0] RST_AMPLITUDE    = 16'd16384;
  localparam logic        RST_PITCH_ENABLE = 1'b0;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RDA  = 7'b0000010,
    S_RDB  = 7'b0000100,
    S_DIFF = 7'b0001000,
    S_INT  = 7'b0010000,
    S_SCL  = 7'b0100000,
    S_SUM  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic take;
    logic ld_a;
    logic ld_mul;
    logic ld_int;
    logic ld_scl;
    logic adv;
  } dp_ctl_t;

  function automatic logic [AW-1:0] store_addr(input logic [31:0] wave,
                                               input logic [31:0] idx);
    logic [31:0] sum;
    sum = (wave << TABLE_BITS) + idx;
    return sum[AW-1:0];
  endfunction

endpackage

[rtl/wosc_in_if.sv]
// Input channel of the wavetable oscillator: valid/ready and one request beat.
// No dependencies.
interface wosc_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [15:0] pitch_mod;
  logic [1:0]         table_wave;
  logic [9:0]         table_index;
  logic signed [15:0] table_value;

  modport source (output valid, req_type, pitch_mod, table_wave, table_index,
                  table_value, input ready);
  modport sink (input valid, req_type, pitch_mod, table_wave, table_index,
                table_value, output ready);
endinterface

[rtl/wosc_out_if.sv]
// Result channel of the wavetable oscillator: valid/ready and one sample beat.
// No dependencies.
interface wosc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink (input valid, sample_out, output ready);
endinterface

[rtl/wosc_ram.sv]
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module wosc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/wosc_dp.sv]
// Oscillator datapath: phase accumulator, interpolation, gain and saturation,
// and the pitch-scaled step. Depends on wosc_pkg; sequenced by the top level.
module wosc_dp import wosc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dp_ctl_t                   ctl,
  input  logic signed [15:0]        pitch_mod,
  input  logic signed [15:0]        rdata,
  input  logic [31:0]               phase_step,
  input  logic [15:0]               amplitude,
  input  logic                      pitch_enable,
  output logic [TABLE_BITS-1:0]     idx0,
  output logic signed [SAMPLE_W-1:0] sample
);

  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic signed [15:0]    pitch_r;
  logic signed [15:0]    a_r;
  logic signed [IW-1:0]  prod_r, prod_nxt;
  logic signed [PPW-1:0] pprod_r, pprod_nxt;
  logic signed [IW-1:0]  interp_r, interp_nxt;
  logic [LW+15:0]        pl_r, pl_nxt;
  logic signed [HW+16:0] ph_r, ph_nxt;

  logic signed [16:0]        diff;
  logic signed [FRAC_BITS:0] frac;
  logic signed [16:0]        fac;
  logic signed [IW-1:0]      a_ext;
  logic [LW-1:0]             lo;
  logic signed [HW-1:0]      hi;
  logic signed [FW-1:0]      full, ysh;
  logic signed [SEW-1:0]     step_ext;

  localparam logic signed [FW-1:0] SAT_HI = FW'(32767);
  localparam logic signed [FW-1:0] SAT_LO = FW'(-32768);

  assign idx0 = phase_r[PHASE_BITS-1:FRAC_BITS];

  always_comb begin
    diff      = 17'(rdata) - 17'(a_r);
    frac      = $signed({1'b0, phase_r[FRAC_BITS-1:0]});
    prod_nxt  = diff * frac;
    fac       = 17'sd16384 + 17'(pitch_r);
    pprod_nxt = $signed({1'b0, phase_step}) * fac;

    a_ext      = IW'(a_r);
    interp_nxt = (a_ext <<< FRAC_BITS) + prod_r;

    lo     = interp_r[LW-1:0];
    hi     = interp_r[IW-1:LW];
    pl_nxt = {16'd0, lo} * {{LW{1'b0}}, amplitude};
    ph_nxt = hi * $signed({1'b0, amplitude});

    full = (FW'(ph_r) <<< LW) + $signed(FW'(pl_r));
    ysh  = full >>> SH;
    if (ysh > SAT_HI) begin
      sample = 16'sh7FFF;
    end else if (ysh < SAT_LO) begin
      sample = 16'sh8000;
    end else begin
      sample = ysh[SAMPLE_W-1:0];
    end

    if (pitch_enable) begin
      step_ext = SEW'(pprod_r >>> 14);
    end else begin
      step_ext = $signed(SEW'(phase_step));
    end
    phase_nxt = phase_r + step_ext[PHASE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (ctl.adv) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      pitch_r <= pitch_mod;
    end
    if (ctl.ld_a) begin
      a_r <= rdata;
    end
    if (ctl.ld_mul) begin
      prod_r  <= prod_nxt;
      pprod_r <= pprod_nxt;
    end
    if (ctl.ld_int) begin
      interp_r <= interp_nxt;
    end
    if (ctl.ld_scl) begin
      pl_r <= pl_nxt;
      ph_r <= ph_nxt;
    end
  end

endmodule

[rtl/wavetable_oscillator_unit.sv]
// Top level of the wavetable oscillator: channels, configuration registers,
// sequencer and waveform store. Depends on wosc_pkg, wosc_in_if, wosc_out_if,
// wosc_ram and wosc_dp.
//
//   channel  | direction | beat
//   in_ch    | sink      | tick or table write (req_type selects)
//   out_ch   | source    | one sample_out per tick
//   cfg_*    | write     | cfg_index selects register, cfg_wdata holds value
//
// A table write goes to the store as it is accepted and gives no beat. A tick
// occupies the sequencer through S_RDA, S_RDB, S_DIFF, S_INT, S_SCL and S_SUM:
// two reads of the single-port store, then a chain of registered multiplies
// for interpolation and gain. The result register lets the next beat be taken
// while a sample waits; a tick only holds in S_SUM if the previous sample is unread.
// Reset is synchronous; the waveform store is not cleared.
module wavetable_oscillator_unit import wosc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  wosc_in_if.sink           in_ch,
  wosc_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  state_t state_r, state_nxt;

  logic [1:0]  wave_select_r;
  logic [31:0] phase_step_r;
  logic [15:0] amplitude_r;
  logic        pitch_enable_r;

  logic                 out_valid_r;
  logic signed [15:0]   sample_r;

  logic                 accept;
  logic                 wr_ok;
  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [15:0]          ram_rdata;
  logic [31:0]          wave_eff;
  logic [TABLE_BITS-1:0] idx0, idx1;
  logic signed [15:0]   sample;
  logic                 out_free;
  dp_ctl_t              ctl;

  assign in_ch.ready   = (state_r == S_IDLE);
  assign accept        = in_ch.valid && in_ch.ready;
  assign wr_ok         = (32'(in_ch.table_wave) < NUM_WAVES) &&
                         (32'(in_ch.table_index) < TSIZE);
  assign ram_we        = accept && (in_ch.req_type == REQ_WRITE) && wr_ok;
  assign wave_eff      = (32'(wave_select_r) < NUM_WAVES) ?
                         32'(wave_select_r) : 32'(NUM_WAVES - 1);
  assign idx1          = idx0 + TABLE_BITS'(1);
  assign out_free      = !out_valid_r || out_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample_out = sample_r;

  always_comb begin
    case (state_r)
      S_RDA:   ram_addr = store_addr(wave_eff, 32'(idx0));
      S_RDB:   ram_addr = store_addr(wave_eff, 32'(idx1));
      default: ram_addr = store_addr(32'(in_ch.table_wave), 32'(in_ch.table_index));
    endcase
  end

  always_comb begin
    ctl.take   = accept && (in_ch.req_type == REQ_TICK);
    ctl.ld_a   = (state_r == S_RDB);
    ctl.ld_mul = (state_r == S_DIFF);
    ctl.ld_int = (state_r == S_INT);
    ctl.ld_scl = (state_r == S_SCL);
    ctl.adv    = (state_r == S_SUM) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (ctl.take) state_nxt = S_RDA;
      end
      S_RDA:  state_nxt = S_RDB;
      S_RDB:  state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_INT;
      S_INT:  state_nxt = S_SCL;
      S_SCL:  state_nxt = S_SUM;
      S_SUM: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      wave_select_r  <= RST_WAVE_SELECT;
      phase_step_r   <= RST_PHASE_STEP;
      amplitude_r    <= RST_AMPLITUDE;
      pitch_enable_r <= RST_PITCH_ENABLE;
    end else begin
      state_r <= state_nxt;
      if (ctl.adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_WAVE_SELECT:  wave_select_r  <= cfg_wdata[1:0];
          CFG_PHASE_STEP:   phase_step_r   <= cfg_wdata[31:0];
          CFG_AMPLITUDE:    amplitude_r    <= cfg_wdata[15:0];
          CFG_PITCH_ENABLE: pitch_enable_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      sample_r <= sample;
    end
  end

  wosc_ram #(
    .WIDTH(16),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_ch.table_value),
    .rdata (ram_rdata)
  );

  wosc_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .pitch_mod    (in_ch.pitch_mod),
    .rdata        ($signed(ram_rdata)),
    .phase_step   (phase_step_r),
    .amplitude    (amplitude_r),
    .pitch_enable (pitch_enable_r),
    .idx0         (idx0),
    .sample       (sample)
  );

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("sequencer state not one-hot");

  a_we_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == S_IDLE) else $error("store written outside idle");

  a_out_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_SUM))
    else $error("sample beat raised without a finished tick");

  a_sum_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM && out_valid_r && !out_ch.ready) |=> state_r == S_SUM)
    else $error("tick finished over an unread sample");

endmodule

[dv/wavetable_oscillator_unit_test.sv]
// Self-checking testbench for wavetable_oscillator_unit: directed and random table
// writes and sample ticks, with a shadow oscillator that predicts every sample beat.
// Depends on wosc_pkg, wosc_in_if, wosc_out_if and the RTL of the block.
module wavetable_oscillator_unit_test;
  import wosc_pkg::*;

  typedef struct {
    logic               req_type;
    logic signed [15:0] pitch_mod;
    logic [1:0]         table_wave;
    logic [9:0]         table_index;
    logic signed [15:0] table_value;
    bit                 gives_sample;
    logic signed [15:0] sample;
  } osc_beat_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  wosc_in_if  in_ch ();
  wosc_out_if out_ch ();

  wavetable_oscillator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic signed [15:0]    wave_mem [STORE_DEPTH];
  bit                    entry_loaded [STORE_DEPTH];
  logic [PHASE_BITS-1:0] phase_acc;
  logic [1:0]            sel_wave;
  logic [31:0]           step_reg;
  logic [15:0]           gain;
  logic                  pitch_on;

  osc_beat_t          beats_pending [$];
  logic signed [15:0] samples_due [$];
  osc_beat_t          on_wire;
  logic signed [15:0] sample_want;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 fault_count;
  int                 items_queued;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_600_000;
    $display("[wavetable_oscillator_unit] ERROR");
    $finish;
  end

  function automatic int unsigned entry_of(input int unsigned k);
    int unsigned w;
    w = (sel_wave < NUM_WAVES) ? sel_wave : NUM_WAVES - 1;
    return w * TSIZE + ((phase_acc[PHASE_BITS-1:FRAC_BITS] + k) % TSIZE);
  endfunction

  function automatic logic signed [15:0] rand_value();
    case ($urandom_range(9))
      0:       return 16'sd32767;
      1:       return -16'sd32768;
      2:       return 16'sd0;
      3:       return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // Interpolates, scales and saturates one sample, then advances the phase.
  function automatic logic signed [15:0] play_tick(input logic signed [15:0] pm);
    longint a, b, f, amp, full, y, s, p, step;
    a = wave_mem[entry_of(0)];
    b = wave_mem[entry_of(1)];
    f = phase_acc[FRAC_BITS-1:0];
    amp = gain;
    full = (a * (longint'(1) << FRAC_BITS) + (b - a) * f) * amp;
    y = full >>> (FRAC_BITS + 14);
    if (pitch_on) begin
      s = step_reg;
      p = pm;
      step = (s * (16384 + p)) >>> 14;
    end else begin
      step = step_reg;
    end
    phase_acc = phase_acc + step[PHASE_BITS-1:0];
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    return y[15:0];
  endfunction

  function automatic void queue_write(input logic [1:0] w, input logic [9:0] idx,
                                      input logic signed [15:0] val);
    osc_beat_t bt;
    bt.req_type = REQ_WRITE;
    bt.pitch_mod = 16'($urandom);
    bt.table_wave = w;
    bt.table_index = idx;
    bt.table_value = val;
    bt.gives_sample = 1'b0;
    bt.sample = '0;
    wave_mem[w * TSIZE + idx] = val;
    entry_loaded[w * TSIZE + idx] = 1'b1;
    beats_pending.push_back(bt);
    items_queued++;
  endfunction

  // Entries that the tick will read are loaded first, so no unwritten entry is ever read.
  function automatic void queue_tick(input logic signed [15:0] pm);
    osc_beat_t   bt;
    int unsigned addr;
    for (int k = 0; k < 2; k++) begin
      addr = entry_of(k);
      if (!entry_loaded[addr])
        queue_write(2'(addr / TSIZE), 10'(addr % TSIZE), rand_value());
    end
    bt.req_type = REQ_TICK;
    bt.pitch_mod = pm;
    bt.table_wave = 2'($urandom);
    bt.table_index = 10'($urandom);
    bt.table_value = 16'($urandom);
    bt.gives_sample = 1'b1;
    bt.sample = play_tick(pm);
    beats_pending.push_back(bt);
    items_queued++;
  endfunction

  task automatic settle();
    do @(negedge clk);
    while (beats_pending.size() != 0 || in_ch.valid || samples_due.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  task automatic set_registers(input logic [1:0] wave, input logic [31:0] step,
                               input logic [15:0] amp, input logic pen);
    logic [31:0] junk;
    junk = $urandom;
    settle();
    write_reg(CFG_WAVE_SELECT, {junk[31:2], wave});
    write_reg(CFG_PHASE_STEP, step);
    write_reg(CFG_AMPLITUDE, {junk[15:0], amp});
    write_reg(CFG_PITCH_ENABLE, {junk[31:1], pen});
    @(posedge clk);
    cfg_we <= 1'b0;
    sel_wave = wave;
    step_reg = step;
    gain = amp;
    pitch_on = pen;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready && on_wire.gives_sample)
        samples_due.push_back(on_wire.sample);
      if (!in_ch.valid || in_ch.ready) begin
        if (beats_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_wire = beats_pending.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.req_type <= on_wire.req_type;
          in_ch.pitch_mod <= on_wire.pitch_mod;
          in_ch.table_wave <= on_wire.table_wave;
          in_ch.table_index <= on_wire.table_index;
          in_ch.table_value <= on_wire.table_value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Every sample beat is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_ch.valid && out_ch.ready) begin
        if (samples_due.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("unexpected sample_out %0d at %0t", out_ch.sample_out, $time);
        end else begin
          sample_want = samples_due.pop_front();
          if (out_ch.sample_out !== sample_want) begin
            fault_count++;
            if (fault_count <= 10)
              $display("sample_out mismatch at %0t: expected %0d, got %0d",
                       $time, sample_want, out_ch.sample_out);
          end
        end
      end
    end
  end

  initial begin
    logic [31:0]        step;
    logic [15:0]        amp;
    logic signed [15:0] pm;
    cfg_we = 1'b0;
    cfg_index = CFG_WAVE_SELECT;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_TICK;
    in_ch.pitch_mod = '0;
    in_ch.table_wave = '0;
    in_ch.table_index = '0;
    in_ch.table_value = '0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    fault_count = 0;
    items_queued = 0;
    phase_acc = '0;
    sel_wave = RST_WAVE_SELECT;
    step_reg = RST_PHASE_STEP;
    gain = RST_AMPLITUDE;
    pitch_on = RST_PITCH_ENABLE;
    send_idle_pct = 19;
    recv_idle_pct = 87;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Full-scale endpoints at zero fraction, pitch field ignored while disabled.
    queue_write(2'd0, 10'd0, 16'sd32767);
    queue_write(2'd0, 10'd1, -16'sd32768);
    queue_tick(16'($urandom));
    queue_tick(16'($urandom));

    // Maximum gain saturates both ways; the all-ones step moves back by one fraction LSB.
    set_registers(2'd3, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    queue_write(2'd3, 10'd19, -16'sd32768);
    queue_write(2'd3, 10'd20, 16'sd32767);
    queue_tick(16'($urandom));
    queue_tick(16'($urandom));
    queue_write(2'd3, 10'd20, -16'sd32768);
    queue_tick(16'($urandom));

    // Pitch extremes: a negative step wraps below zero, the last entry pairs with entry 0.
    set_registers(2'd1, 32'(20) << FRAC_BITS, 16'd16384, 1'b1);
    queue_tick(-16'sd32768);
    queue_tick(16'sd32767);
    queue_tick(-16'sd16384);
    queue_tick(16'sd0);

    for (int p = 3; p < 12; p++) begin
      case (p % 5)
        0, 4: step = $urandom_range(32'h0400_0000);
        1:    step = $urandom;
        2:    step = 32'hFFFF_FFFF;
        default: step = '0;
      endcase
      case (p % 4)
        0:       amp = 16'hFFFF;
        1:       amp = 16'($urandom);
        2:       amp = 16'd16384;
        default: amp = '0;
      endcase
      set_registers(2'($urandom), step, amp, p[0]);
      if (p >= 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (p >= 5) begin
        send_idle_pct = 87;
        recv_idle_pct = 19;
      end
      while (items_queued < (p - 2) * 166) begin
        if ($urandom_range(99) < 70) begin
          case ($urandom_range(7))
            0:       pm = -16'sd32768;
            1:       pm = 16'sd32767;
            2:       pm = -16'sd16384;
            3:       pm = 16'sd0;
            default: pm = 16'($urandom);
          endcase
          queue_tick(pm);
        end else begin
          queue_write(2'($urandom), 10'($urandom), rand_value());
        end
      end
    end

    settle();
    if (fault_count == 0 && samples_due.size() == 0)
      $display("[wavetable_oscillator_unit] OK");
    else
      $display("[wavetable_oscillator_unit] ERROR");
    $finish;
  end

endmodule
